>>> sv/tdr_suc_pkg.sv
package tdr_suc_pkg;

  // Configuration port
  localparam int CFG_W = 16;
  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_OFFSET    = 2'd0;
  localparam logic [IDX_W-1:0] REG_AMPLITUDE = 2'd1;
  localparam logic [IDX_W-1:0] REG_UNIT      = 2'd2;

  // Vertical unit codes
  localparam int UNIT_W = 2;
  localparam logic [UNIT_W-1:0] VU_MV     = 2'd0;
  localparam logic [UNIT_W-1:0] VU_NORMAL = 2'd1;
  localparam logic [UNIT_W-1:0] VU_OHMS   = 2'd2;
  localparam logic [UNIT_W-1:0] VU_RHO    = 2'd3;

  localparam logic [CFG_W-1:0] AMPLITUDE_RESET = 16'd10864;

  // Datapath widths
  localparam int RAW_W = 16;
  localparam int N_W   = 22;          // 16*raw - offset, signed
  localparam int X_W   = 21;          // magnitude of the scaled operand
  localparam int K_W   = 8;           // unit gain
  localparam int P_W   = X_W + K_W;   // gain times operand
  localparam int D_W   = 18;          // divisor, up to twice the amplitude
  localparam int Q_W   = 32;          // quotient and result width

  localparam logic [K_W-1:0] K_MV   = 8'd250;
  localparam logic [K_W-1:0] K_OHM  = 8'd50;
  localparam logic [K_W-1:0] K_UNIT = 8'd1;

  localparam logic [Q_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] SAT_NEG = 32'h8000_0000;

  // Per-item control carried down the pipeline
  typedef struct packed {
    logic           last;
    logic           neg;
    logic           is_const;
    logic           const_sat;
    logic [Q_W-1:0] const_val;
    logic [D_W-1:0] den;
  } ctl_t;

endpackage

>>> sv/tdr_sample_unit_conversion.sv
// Reflectometer sample unit conversion.
// Input channel: raw_sample and last_in move on in_valid; the block holds
// in_stall high when it cannot take a transfer. Output channel: converted_value,
// saturated and last_out move on out_valid, and the receiver holds out_stall
// high to refuse a transfer. One result leaves for every sample taken, in order.
// Configuration: pulse cfg_write with cfg_index (0 offset, 1 amplitude,
// 2 vertical unit) and cfg_data; write only while no sample is in flight.
// Throughput is one sample per clock while no result is held by out_stall:
// four stages form n, choose the unit, multiply by the unit gain and add the
// rounding bias, a fifth flags quotients that do not fit in 32 bits and seeds
// the remainder, then a 32-stage restoring divider produces one quotient bit
// per stage, and a final stage fixes the sign and clips to 32 bits.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_stall follows out_stall in that cycle; nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipeline and sets offset 0, amplitude
// 10864 and the millivolt unit. An amplitude of 0 is taken as 1.
module tdr_sample_unit_conversion #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [tdr_suc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [tdr_suc_pkg::CFG_W-1:0]   cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tdr_suc_pkg::RAW_W-1:0]   raw_sample,
  input  logic                            last_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [tdr_suc_pkg::Q_W-1:0] converted_value,
  output logic                            saturated,
  output logic                            last_out
);
  import tdr_suc_pkg::*;

  localparam int M_W  = P_W + FRAC_BITS + 1;
  localparam int HI_W = M_W - Q_W;
  localparam int C_W  = (HI_W > D_W) ? HI_W : D_W;

  localparam logic [63:0] ONE         = 64'd1 << FRAC_BITS;
  localparam logic [63:0] NEAR_ONE    = (999 * ONE + 64'd500) / 64'd1000;
  localparam logic [63:0] NEG_NEAR    = 64'd0 - NEAR_ONE;
  localparam logic [63:0] OHM_LOW     = (50 * ONE + 64'd999) / 64'd1999;
  localparam logic [63:0] OHM_TOP     = 500 * ONE;
  localparam logic        OHM_TOP_SAT = OHM_TOP > 64'h7FFF_FFFF;
  localparam logic [Q_W-1:0] OHM_TOP_VAL = OHM_TOP_SAT ? SAT_POS : OHM_TOP[Q_W-1:0];

  // Configuration registers
  logic [CFG_W-1:0]  sample_offset;
  logic [CFG_W-1:0]  step_amplitude;
  logic [UNIT_W-1:0] vertical_unit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_offset  <= '0;
      step_amplitude <= AMPLITUDE_RESET;
      vertical_unit  <= VU_MV;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_OFFSET:    sample_offset  <= cfg_data;
        REG_AMPLITUDE: step_amplitude <= cfg_data;
        REG_UNIT:      vertical_unit  <= cfg_data[UNIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: hold every stage while a result waits under stall
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 1: form n = 16*raw - offset
  logic                s1_vld;
  logic signed [N_W-1:0] s1_n;
  logic [CFG_W-1:0]    s1_amp;
  logic [UNIT_W-1:0]   s1_unit;
  logic                s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_n    <= $signed({2'b00, raw_sample, 4'b0000}) - $signed({6'b0, sample_offset});
      s1_amp  <= (step_amplitude == '0) ? CFG_W'(1) : step_amplitude;
      s1_unit <= vertical_unit;
      s1_last <= last_in;
    end
  end

  // Stage 2: decide clamps, pick operand, gain and divisor
  logic signed [N_W:0]   n_ext;
  logic signed [N_W:0]   a_ext;
  logic signed [N_W:0]   a_x2;
  logic signed [N_W:0]   n_minus_a;
  logic signed [N_W:0]   ohm_den;
  logic signed [N_W+4:0] n_wide;
  logic signed [N_W+4:0] a_wide;
  logic signed [N_W+4:0] n_x11;
  logic signed [N_W+4:0] a_x20;
  logic                  n_neg;
  logic                  n_pos;
  logic signed [N_W:0]   sel_x;
  logic [N_W:0]          sel_abs;
  logic [K_W-1:0]        sel_k;
  ctl_t                  sel_ctl;

  always_comb begin
    n_ext     = {s1_n[N_W-1], s1_n};
    a_ext     = $signed({7'b0, s1_amp});
    a_x2      = a_ext <<< 1;
    n_minus_a = n_ext - a_ext;
    ohm_den   = a_x2 - n_ext;
    n_wide    = {{5{s1_n[N_W-1]}}, s1_n};
    a_wide    = $signed({11'b0, s1_amp});
    n_x11     = (n_wide <<< 3) + (n_wide <<< 1) + n_wide;
    a_x20     = (a_wide <<< 4) + (a_wide <<< 2);
    n_neg     = s1_n[N_W-1];
    n_pos     = !n_neg && (s1_n != '0);

    sel_x             = '0;
    sel_k             = K_UNIT;
    sel_ctl.last      = s1_last;
    sel_ctl.neg       = 1'b0;
    sel_ctl.is_const  = 1'b0;
    sel_ctl.const_sat = 1'b0;
    sel_ctl.const_val = '0;
    sel_ctl.den       = {2'b00, s1_amp};

    case (s1_unit)
      VU_MV: begin
        sel_x = n_minus_a;
        sel_k = K_MV;
      end
      VU_NORMAL: begin
        if (n_neg) begin
          sel_ctl.is_const = 1'b1;
        end else begin
          sel_x = n_ext;
        end
      end
      VU_OHMS: begin
        if (!n_pos) begin
          sel_ctl.is_const  = 1'b1;
          sel_ctl.const_val = OHM_LOW[Q_W-1:0];
        end else if (n_x11 >= a_x20) begin
          sel_ctl.is_const  = 1'b1;
          sel_ctl.const_val = OHM_TOP_VAL;
          sel_ctl.const_sat = OHM_TOP_SAT;
        end else begin
          sel_x       = n_ext;
          sel_k       = K_OHM;
          sel_ctl.den = ohm_den[D_W-1:0];
        end
      end
      default: begin
        if (!n_pos) begin
          sel_ctl.is_const  = 1'b1;
          sel_ctl.const_val = NEG_NEAR[Q_W-1:0];
        end else if (n_ext >= a_x2) begin
          sel_ctl.is_const  = 1'b1;
          sel_ctl.const_val = NEAR_ONE[Q_W-1:0];
        end else begin
          sel_x = n_minus_a;
        end
      end
    endcase

    sel_ctl.neg = sel_x[N_W];
    sel_abs     = sel_x[N_W] ? $unsigned(-sel_x) : $unsigned(sel_x);
  end

  logic           s2_vld;
  logic [X_W-1:0] s2_mag;
  logic [K_W-1:0] s2_k;
  ctl_t           s2_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mag <= sel_abs[X_W-1:0];
      s2_k   <= sel_k;
      s2_ctl <= sel_ctl;
    end
  end

  // Stage 3: apply the unit gain
  logic           s3_vld;
  logic [P_W-1:0] s3_prod;
  ctl_t           s3_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (adv) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_prod <= {{K_W{1'b0}}, s2_mag} * {{X_W{1'b0}}, s2_k};
      s3_ctl  <= s2_ctl;
    end
  end

  // Stage 4: scale to fixed point and add half the divisor for rounding
  logic           s4_vld;
  logic [M_W-1:0] s4_m;
  ctl_t           s4_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (adv) begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_m   <= {1'b0, s3_prod, {FRAC_BITS{1'b0}}} + M_W'(s3_ctl.den >> 1);
      s4_ctl <= s3_ctl;
    end
  end

  // Stage 5: flag quotients that do not fit in 32 bits, seed the remainder
  logic [HI_W-1:0] num_hi;
  logic [C_W-1:0]  num_hi_ext;
  logic            num_ov;

  assign num_hi     = s4_m[M_W-1:Q_W];
  assign num_hi_ext = C_W'(num_hi);
  assign num_ov     = num_hi_ext >= C_W'(s4_ctl.den);

  logic [Q_W:0]   div_vld;
  logic [Q_W:0]   div_ov;
  logic [D_W-1:0] div_rem  [0:Q_W];
  logic [Q_W-1:0] div_work [0:Q_W];
  ctl_t           div_ctl  [0:Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_vld[0] <= 1'b0;
    end else if (adv) begin
      div_vld[0] <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_ov[0]   <= num_ov;
      div_rem[0]  <= num_ov ? '0 : num_hi_ext[D_W-1:0];
      div_work[0] <= s4_m[Q_W-1:0];
      div_ctl[0]  <= s4_ctl;
    end
  end

  // Divider: one restoring step per stage, quotient bits shift in at the bottom
  for (genvar j = 1; j <= Q_W; j++) begin : g_div
    logic [D_W:0] trial;
    logic [D_W:0] diff;
    logic         take;

    assign trial = {div_rem[j-1], div_work[j-1][Q_W-1]};
    assign diff  = trial - {1'b0, div_ctl[j-1].den};
    assign take  = !diff[D_W];

    always_ff @(posedge clk) begin
      if (rst) begin
        div_vld[j] <= 1'b0;
      end else if (adv) begin
        div_vld[j] <= div_vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_ov[j]   <= div_ov[j-1];
        div_rem[j]  <= take ? diff[D_W-1:0] : trial[D_W-1:0];
        div_work[j] <= {div_work[j-1][Q_W-2:0], take};
        div_ctl[j]  <= div_ctl[j-1];
      end
    end
  end

  // Final stage: restore the sign and clip to the 32-bit range
  logic [Q_W-1:0] quo;
  ctl_t           fin_ctl;
  logic [Q_W-1:0] fin_val;
  logic           fin_sat;

  always_comb begin
    quo     = div_work[Q_W];
    fin_ctl = div_ctl[Q_W];
    fin_val = quo;
    fin_sat = 1'b0;
    if (fin_ctl.is_const) begin
      fin_val = fin_ctl.const_val;
      fin_sat = fin_ctl.const_sat;
    end else if (div_ov[Q_W]) begin
      fin_val = fin_ctl.neg ? SAT_NEG : SAT_POS;
      fin_sat = 1'b1;
    end else if (!fin_ctl.neg) begin
      if (quo[Q_W-1]) begin
        fin_val = SAT_POS;
        fin_sat = 1'b1;
      end
    end else if (quo > SAT_NEG) begin
      fin_val = SAT_NEG;
      fin_sat = 1'b1;
    end else begin
      fin_val = ~quo + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= div_vld[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      converted_value <= $signed(fin_val);
      saturated       <= fin_sat;
      last_out        <= fin_ctl.last;
    end
  end

`ifndef SYNTHESIS
  // The divider remainder never reaches the divisor
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    div_vld[Q_W] |-> (div_rem[Q_W] < div_ctl[Q_W].den))
    else $error("divider remainder not below divisor");

  // A saturated result sits at one of the two field limits
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (converted_value == $signed(SAT_POS)) || (converted_value == $signed(SAT_NEG)))
    else $error("saturated result not at a field limit");

  // Under a stalled result the divider stages keep their occupancy
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(div_vld))
    else $error("pipeline moved while output stalled");

  // A transfer in always lands in the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_vld)
    else $error("accepted sample did not enter the pipeline");
`endif

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tdr_suc_pkg::*;

  localparam int FRAC = 16;
  localparam int RANDOM_PHASES = 25;
  localparam int SAMPLES_PER_PHASE = 70;
  localparam int SETTLE_CYCLES = 50;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic signed [Q_W-1:0] value;
    logic                  sat;
    logic                  last;
  } sample_result_t;

  // One directed probe: settings, sample, and a hand-worked result where obvious
  typedef struct packed {
    logic [UNIT_W-1:0]     unit;
    logic [CFG_W-1:0]      offs;
    logic [CFG_W-1:0]      amp;
    logic [RAW_W-1:0]      raw;
    logic                  last;
    logic                  typed;
    logic signed [Q_W-1:0] val;
    logic                  sat;
  } probe_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [RAW_W-1:0]      raw_sample = '0;
  logic                  last_in = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [Q_W-1:0] converted_value;
  logic                  saturated;
  logic                  last_out;

  logic                  steady_flow = 1'b0;
  int                    fail_count = 0;
  int                    idle_cycles = 0;

  // Mirror of the block's settings, updated on each write
  logic [CFG_W-1:0]      cur_offset = '0;
  logic [CFG_W-1:0]      cur_amplitude = AMPLITUDE_RESET;
  logic [UNIT_W-1:0]     cur_unit = VU_MV;

  sample_result_t        expected_results[$];

  probe_row_t probes [0:24] = '{
    '{VU_MV,     16'd0,     16'd10864, 16'd0,     1'b0, 1'b1, -32'sd16384000, 1'b0},
    '{VU_MV,     16'd0,     16'd10864, 16'd679,   1'b1, 1'b1, 32'sd0,         1'b0},
    '{VU_MV,     16'd0,     16'd10864, 16'd65535, 1'b0, 1'b0, 32'sd0,         1'b0},
    '{VU_NORMAL, 16'd0,     16'd10864, 16'd679,   1'b0, 1'b1, 32'sd65536,     1'b0},
    '{VU_NORMAL, 16'd65535, 16'd10864, 16'd0,     1'b1, 1'b1, 32'sd0,         1'b0},
    '{VU_NORMAL, 16'd0,     16'd1,     16'd65535, 1'b0, 1'b1, 32'sh7FFF_FFFF, 1'b1},
    '{VU_NORMAL, 16'd0,     16'd1,     16'd0,     1'b0, 1'b1, 32'sd0,         1'b0},
    '{VU_MV,     16'd0,     16'd1,     16'd65535, 1'b1, 1'b1, 32'sh7FFF_FFFF, 1'b1},
    '{VU_MV,     16'd65535, 16'd1,     16'd0,     1'b0, 1'b1, 32'sh8000_0000, 1'b1},
    '{VU_MV,     16'd0,     16'd0,     16'd1,     1'b0, 1'b1, 32'sd245760000, 1'b0},
    '{VU_RHO,    16'd0,     16'd10864, 16'd0,     1'b0, 1'b1, -32'sd65470,    1'b0},
    '{VU_RHO,    16'd0,     16'd10864, 16'd1358,  1'b1, 1'b1, 32'sd65470,     1'b0},
    '{VU_RHO,    16'd0,     16'd10864, 16'd679,   1'b0, 1'b1, 32'sd0,         1'b0},
    '{VU_RHO,    16'd0,     16'd10864, 16'd1000,  1'b0, 1'b0, 32'sd0,         1'b0},
    '{VU_RHO,    16'd0,     16'd10864, 16'd65535, 1'b0, 1'b1, 32'sd65470,     1'b0},
    '{VU_OHMS,   16'd0,     16'd10864, 16'd0,     1'b0, 1'b1, 32'sd1639,      1'b0},
    '{VU_OHMS,   16'd0,     16'd10864, 16'd679,   1'b1, 1'b1, 32'sd3276800,   1'b0},
    '{VU_OHMS,   16'd0,     16'd10864, 16'd65535, 1'b0, 1'b1, 32'sd32768000,  1'b0},
    '{VU_OHMS,   16'd0,     16'd10864, 16'd1234,  1'b0, 1'b0, 32'sd0,         1'b0},
    '{VU_OHMS,   16'd0,     16'd10864, 16'd1235,  1'b0, 1'b0, 32'sd0,         1'b0},
    '{VU_OHMS,   16'd65535, 16'd65535, 16'd65535, 1'b0, 1'b0, 32'sd0,         1'b0},
    '{VU_RHO,    16'd16,    16'd1,     16'd1,     1'b0, 1'b0, 32'sd0,         1'b0},
    '{VU_NORMAL, 16'd8,     16'd3,     16'd1,     1'b0, 1'b0, 32'sd0,         1'b0},
    '{VU_MV,     16'd15,    16'd7,     16'd1,     1'b1, 1'b0, 32'sd0,         1'b0},
    '{VU_MV,     16'd65535, 16'd65535, 16'd65535, 1'b1, 1'b0, 32'sd0,         1'b0}
  };

  tdr_sample_unit_conversion #(
    .FRAC_BITS(FRAC)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .raw_sample(raw_sample),
    .last_in(last_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .converted_value(converted_value),
    .saturated(saturated),
    .last_out(last_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Divide rounding to nearest, ties away from zero; den is positive
  function automatic longint round_div(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  // Work out the converted value of one sample under the current settings
  function automatic sample_result_t convert_sample(logic [RAW_W-1:0] raw, logic last);
    longint one, near_one, a, n, v;
    sample_result_t r;
    one = longint'(1) << FRAC;
    near_one = round_div(999 * one, 1000);
    a = (cur_amplitude == 0) ? 1 : longint'(cur_amplitude);
    n = longint'(raw) * 16 - longint'(cur_offset);
    case (cur_unit)
      VU_MV: v = round_div(250 * (n - a) * one, a);
      VU_NORMAL: v = (n < 0) ? 0 : round_div(n * one, a);
      VU_OHMS: begin
        if (n <= 0) v = round_div(50 * one, 1999);
        else if (11 * n >= 20 * a) v = 500 * one;
        else v = round_div(50 * n * one, 2 * a - n);
      end
      default: begin
        if (n <= 0) v = -near_one;
        else if (n >= 2 * a) v = near_one;
        else v = round_div((n - a) * one, a);
      end
    endcase
    r.sat = 1'b0;
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
      r.sat = 1'b1;
    end else if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
      r.sat = 1'b1;
    end
    r.value = v[Q_W-1:0];
    r.last = last;
    return r;
  endfunction

  // Pick a sample, mostly aimed at the clamp and knee points of the current setting
  function automatic logic [RAW_W-1:0] pick_raw();
    longint a, t, r;
    a = (cur_amplitude == 0) ? 1 : longint'(cur_amplitude);
    case ($urandom_range(9))
      0, 1, 2: r = $urandom_range(65535);
      3: r = $urandom_range(1) ? 65535 : 0;
      4, 5: begin
        case ($urandom_range(3))
          0: t = 0;
          1: t = a;
          2: t = 2 * a;
          default: t = (20 * a) / 11;
        endcase
        r = ((t + longint'(cur_offset)) >>> 4) + int'($urandom_range(2)) - 1;
      end
      default: begin
        t = longint'($urandom_range(32'(4 * a))) - a;
        r = (t + longint'(cur_offset)) >>> 4;
      end
    endcase
    if (r < 0) r = 0;
    else if (r > 65535) r = 65535;
    return r[RAW_W-1:0];
  endfunction

  // Drop valid and wait until every pending result has come back
  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Write all three registers with the block idle
  task automatic load_settings(logic [CFG_W-1:0] offs, logic [CFG_W-1:0] amp,
                               logic [UNIT_W-1:0] unit);
    settle_pipeline();
    cfg_write <= 1'b1;
    cfg_index <= REG_OFFSET;
    cfg_data <= offs;
    @(posedge clk);
    cfg_index <= REG_AMPLITUDE;
    cfg_data <= amp;
    @(posedge clk);
    cfg_index <= REG_UNIT;
    cfg_data <= {{(CFG_W-UNIT_W){1'b0}}, unit};
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_offset = offs;
    cur_amplitude = amp;
    cur_unit = unit;
  endtask

  // Offer one sample, hold it until the transfer, then log what should come out
  task automatic send_sample(logic [RAW_W-1:0] raw, logic last, logic typed,
                             sample_result_t typed_res);
    while (!steady_flow && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_sample <= raw;
    last_in <= last;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(typed ? typed_res : convert_sample(raw, last));
  endtask

  // Stall the output at random and check every result transfer
  always @(posedge clk) begin
    sample_result_t want;
    out_stall <= !steady_flow && ($urandom_range(99) < 37);
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result: value %0d sat %0b last %0b",
                   converted_value, saturated, last_out);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (converted_value !== want.value || saturated !== want.sat ||
            last_out !== want.last) begin
          if (fail_count < 10)
            $display("mismatch: expected value %0d sat %0b last %0b, got %0d sat %0b last %0b",
                     want.value, want.sat, want.last, converted_value, saturated, last_out);
          fail_count++;
        end
      end
    end
  end

  // Abort if nothing moves for too long
  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [CFG_W-1:0]  offs;
    logic [CFG_W-1:0]  amp;
    logic [UNIT_W-1:0] unit;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed probes; the first ones run on the reset settings
    foreach (probes[i]) begin
      if (probes[i].unit != cur_unit || probes[i].offs != cur_offset ||
          probes[i].amp != cur_amplitude)
        load_settings(probes[i].offs, probes[i].amp, probes[i].unit);
      send_sample(probes[i].raw, probes[i].last, probes[i].typed,
                  '{probes[i].val, probes[i].sat, probes[i].last});
    end

    // Random phases: extreme settings first, then random ones
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 4) begin
        unit = p[UNIT_W-1:0];
        offs = p[0] ? 16'hFFFF : 16'h0000;
        amp = p[1] ? 16'hFFFF : 16'h0001;
      end else begin
        unit = UNIT_W'($urandom_range(3));
        case ($urandom_range(3))
          0: offs = 16'h0000;
          1: offs = 16'hFFFF;
          default: offs = CFG_W'($urandom_range(65535));
        endcase
        case ($urandom_range(5))
          0: amp = 16'h0000;
          1: amp = 16'h0001;
          2: amp = 16'hFFFF;
          3: amp = AMPLITUDE_RESET;
          4: amp = CFG_W'($urandom_range(64, 1));
          default: amp = CFG_W'($urandom_range(65535, 1));
        endcase
      end
      load_settings(offs, amp, unit);
      // hold a stretch of phases with no idling on either side
      steady_flow <= (p >= 12 && p < 16);
      for (int k = 0; k < SAMPLES_PER_PHASE; k++)
        send_sample(pick_raw(), $urandom_range(7) == 0, 1'b0, '0);
    end

    settle_pipeline();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
